// ----- src/hdm_pkg.sv -----
// Shared constants, types and the djb2 step for the HMAC-djb2 tag core.
`default_nettype none
package hdm_pkg;

	localparam int          KEY_BYTES_DEF = 64;
	localparam int          KEY_WORDS     = 8;
	localparam int          KEY_REG_BYTES = 64;
	localparam int          KEY_AW        = 6;
	localparam int          HASH_SHIFT    = 5;
	localparam logic [31:0] HASH_START    = 32'd5381;
	localparam logic [7:0]  INNER_PAD     = 8'h36;
	localparam logic [7:0]  OUTER_PAD     = 8'h5C;
	localparam logic [1:0]  TAG_LAST      = 2'd3;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PRIME = 5'b00010,
		ST_PAD   = 5'b00100,
		ST_BYTE  = 5'b01000,
		ST_TAG   = 5'b10000
	} hdm_state_t;

	function automatic logic [31:0] djb2_step(input logic [31:0] h, input logic [7:0] b);
		return (h << HASH_SHIFT) + h + {24'b0, b};
	endfunction

endpackage
`default_nettype wire

// ----- src/hmac_djb2_mac_core.sv -----
// HMAC-style 32-bit tag engine built on a single shared djb2 step unit.
//
// Bytes of an open message are absorbed one per cycle while s_tready is high.
// The first word of a message is held while the core primes the key memory
// read, hashes the inner pad and then absorbs the word's own byte, before the
// next word is taken. The word that carries tlast is absorbed into the inner
// hash, the core then hashes the outer pad and the four inner hash bytes, and
// the tag then sits in the output register while new words are accepted. A
// single djb2 adder (h*33+b) and the single pad read port of the key memory
// serve all of these steps. The key is written through the APB port at byte
// address 8*i for key word i and reads back through a registered read port.
`default_nettype none
module hmac_djb2_mac_core
	import hdm_pkg::*;
#(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,  // [7:0] data_byte
	input  wire logic              s_tuser,  // [0] no_data
	input  wire logic              s_tlast,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [31:0]            m_tdata,  // [31:0] mac
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [KEY_AW-1:0] paddr,
	input  wire logic [63:0]       pwdata,
	output logic [63:0]            prdata,
	output logic                   pready
);

	localparam int PAD_W = $clog2(KEY_BYTES);

	hdm_state_t state_q;

	logic [63:0] key_mem [KEY_WORDS];
	logic [KEY_WORDS-1:0] key_vld_q;
	logic [63:0] prd_word_q;
	logic        prd_vld_q;
	logic [63:0] word_s1;
	logic        vld_s1;
	logic        rng_s1;
	logic [2:0]  off_s1;

	logic [31:0]      h_q;
	logic [31:0]      inner_q;
	logic [31:0]      out_q;
	logic             m_tvalid_q;
	logic             in_msg_q;
	logic             outer_q;
	logic             ended_q;
	logic [PAD_W-1:0] cnt_q;
	logic [1:0]       tag_q;
	logic [7:0]       held_byte_q;
	logic             held_nd_q;
	logic             held_last_q;

	logic [PAD_W-1:0] rd_idx;
	logic [31:0]      rd_ext;
	logic             wr_en;
	logic [7:0]       key_byte;
	logic [7:0]       pad_byte;
	logic [7:0]       tag_byte;
	logic [7:0]       b_op;
	logic [31:0]      h_nxt;
	logic             tag_fire;

	assign pready   = 1'b1;
	assign prdata   = prd_vld_q ? prd_word_q : 64'd0;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;
	assign wr_en    = psel && penable && pwrite;
	assign tag_fire = (state_q == ST_TAG) && (tag_q == TAG_LAST) && (!m_tvalid_q || m_tready);

	assign rd_idx = (state_q == ST_PAD) ? cnt_q + 1'b1 : '0;
	assign rd_ext = 32'(rd_idx);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[paddr[5:3]] <= pwdata;
		end
		if (psel && !penable) begin
			prd_word_q <= key_mem[paddr[5:3]];
		end
		word_s1 <= key_mem[rd_ext[5:3]];
		off_s1  <= rd_ext[2:0];
		rng_s1  <= (rd_ext < 32'(KEY_REG_BYTES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_vld_q <= '0;
			prd_vld_q <= 1'b0;
			vld_s1    <= 1'b0;
		end else begin
			if (wr_en) begin
				key_vld_q[paddr[5:3]] <= 1'b1;
			end
			if (psel && !penable) begin
				prd_vld_q <= key_vld_q[paddr[5:3]];
			end
			vld_s1 <= key_vld_q[rd_ext[5:3]];
		end
	end

	assign key_byte = (vld_s1 && rng_s1 && !ended_q) ? word_s1[{off_s1, 3'b000} +: 8] : 8'd0;
	assign pad_byte = key_byte ^ (outer_q ? OUTER_PAD : INNER_PAD);
	assign tag_byte = inner_q[{tag_q, 3'b000} +: 8];

	always_comb begin
		unique case (state_q)
			ST_IDLE: b_op = s_tdata;
			ST_BYTE: b_op = held_byte_q;
			ST_PAD:  b_op = pad_byte;
			ST_TAG:  b_op = tag_byte;
			default: b_op = 8'd0;
		endcase
	end

	assign h_nxt = djb2_step(h_q, b_op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			h_q         <= HASH_START;
			inner_q     <= '0;
			out_q       <= '0;
			m_tvalid_q  <= 1'b0;
			in_msg_q    <= 1'b0;
			outer_q     <= 1'b0;
			ended_q     <= 1'b0;
			cnt_q       <= '0;
			tag_q       <= '0;
			held_byte_q <= '0;
			held_nd_q   <= 1'b0;
			held_last_q <= 1'b0;
		end else begin
			if (tag_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (!in_msg_q) begin
							held_byte_q <= s_tdata;
							held_nd_q   <= s_tuser;
							held_last_q <= s_tlast;
							h_q         <= HASH_START;
							outer_q     <= 1'b0;
							in_msg_q    <= 1'b1;
							state_q     <= ST_PRIME;
						end else begin
							if (s_tlast) begin
								inner_q <= s_tuser ? h_q : h_nxt;
								h_q     <= HASH_START;
								outer_q <= 1'b1;
								state_q <= ST_PRIME;
							end else if (!s_tuser) begin
								h_q <= h_nxt;
							end
						end
					end
				end
				ST_PRIME: begin
					cnt_q   <= '0;
					ended_q <= 1'b0;
					state_q <= ST_PAD;
				end
				ST_PAD: begin
					h_q     <= h_nxt;
					ended_q <= ended_q || (key_byte == 8'd0);
					cnt_q   <= cnt_q + 1'b1;
					tag_q   <= '0;
					if (cnt_q == PAD_W'(KEY_BYTES - 1)) begin
						state_q <= outer_q ? ST_TAG : ST_BYTE;
					end
				end
				ST_BYTE: begin
					if (held_last_q) begin
						inner_q <= held_nd_q ? h_q : h_nxt;
						h_q     <= HASH_START;
						outer_q <= 1'b1;
						state_q <= ST_PRIME;
					end else begin
						if (!held_nd_q) begin
							h_q <= h_nxt;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_TAG: begin
					if (tag_q != TAG_LAST) begin
						h_q   <= h_nxt;
						tag_q <= tag_q + 1'b1;
					end else if (tag_fire) begin
						out_q    <= h_nxt;
						h_q      <= HASH_START;
						in_msg_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/hdm_chk.sv -----
// Port-level checker for the HMAC-djb2 tag core, with its bind.
`default_nettype none
module hdm_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        pready
);

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input still ready after a last word");

	a_tag_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("tag appeared without a busy cycle before it");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output word changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind hmac_djb2_mac_core hdm_chk u_hdm_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for hmac_djb2_mac_core: keyed djb2 tags over byte streams.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hdm_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int LIMIT_CYCLES = 600000;
	localparam int PAD_LEN      = KEY_BYTES_DEF;
	localparam int KEY_STRIDE   = 8;
	localparam int MAX_GAP      = 12;
	localparam int RANDOM_WORDS = 380;

	typedef logic [63:0] key_t [KEY_WORDS];
	typedef enum int {KEY_ZERO, KEY_ONES, KEY_RAW, KEY_FULL, KEY_CUT} key_kind_t;

	logic              clk;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	wire logic         s_tready;
	logic [7:0]        s_tdata  = 8'h00;  // [7:0] data_byte
	logic              s_tuser  = 1'b0;   // [0] no_data
	logic              s_tlast  = 1'b0;
	wire logic         m_tvalid;
	logic              m_tready = 1'b0;
	wire logic [31:0]  m_tdata;           // [31:0] mac
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [KEY_AW-1:0] paddr    = '0;
	logic [63:0]       pwdata   = '0;
	wire logic [63:0]  prdata;
	wire logic         pready;

	key_t        key_shadow = '{default: 64'd0};
	logic [31:0] msg_hash   = HASH_START;
	bit          msg_open   = 1'b0;
	logic [31:0] tags_due [$];
	logic [31:0] tag_want;

	bit          idle_on     = 1'b1;
	int unsigned stall_left  = 0;
	int unsigned hold_req    = 0;
	int unsigned words_sent  = 0;
	int unsigned msgs_sent   = 0;
	int unsigned keys_loaded = 0;
	int unsigned tags_seen   = 0;
	int unsigned errors      = 0;

	hmac_djb2_mac_core #(
		.KEY_BYTES(PAD_LEN)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	initial begin
		#(HALF_PERIOD * 2 * LIMIT_CYCLES);
		$display("tb_top failed");
		$finish;
	end

	function automatic logic [31:0] djb2_mix(logic [31:0] h, logic [7:0] b);
		return h * 32'd33 + {24'd0, b};
	endfunction

	function automatic logic [31:0] pad_hash(logic [7:0] pad);
		logic [31:0] h;
		logic [7:0]  kb;
		bit          ended;
		h = HASH_START;
		ended = 1'b0;
		for (int i = 0; i < PAD_LEN; i++) begin
			kb = 8'h00;
			if (i < KEY_REG_BYTES && !ended) begin
				kb = key_shadow[i / 8][(i % 8) * 8 +: 8];
				if (kb == 8'h00)
					ended = 1'b1;
			end
			h = djb2_mix(h, kb ^ pad);
		end
		return h;
	endfunction

	function automatic key_t make_key(key_kind_t kind);
		key_t       k;
		int         cut;
		logic [7:0] b;
		cut = $urandom_range(0, KEY_REG_BYTES - 1);
		for (int i = 0; i < KEY_REG_BYTES; i++) begin
			case (kind)
				KEY_ZERO: b = 8'h00;
				KEY_ONES: b = 8'hFF;
				KEY_RAW:  b = 8'($urandom);
				default:  b = 8'($urandom_range(1, 255));
			endcase
			if (kind == KEY_CUT && i == cut)
				b = 8'h00;
			k[i / 8][(i % 8) * 8 +: 8] = b;
		end
		return k;
	endfunction

	// receiver: hold tready low for the drawn stall, or for a requested hold-off
	always @(negedge clk) begin
		if (hold_req != 0) begin
			stall_left = hold_req;
			hold_req = 0;
		end
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (tags_due.size() == 0) begin
				$error("mac: no tag expected, got %08h", m_tdata);
				errors++;
			end else begin
				tag_want = tags_due.pop_front();
				if (m_tdata !== tag_want) begin
					$error("mac: expected %08h, got %08h", tag_want, m_tdata);
					errors++;
				end
			end
			tags_seen++;
			stall_left = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		end
	end

	task automatic send_word(input logic [7:0] d, input logic nd, input logic last);
		int unsigned gap;
		logic [31:0] t;
		gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= nd;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (!msg_open) begin
			msg_hash = pad_hash(INNER_PAD);
			msg_open = 1'b1;
		end
		if (!nd)
			msg_hash = djb2_mix(msg_hash, d);
		if (last) begin
			t = pad_hash(OUTER_PAD);
			for (int k = 0; k < 4; k++)
				t = djb2_mix(t, msg_hash[k * 8 +: 8]);
			tags_due.push_back(t);
			msg_open = 1'b0;
			msgs_sent++;
		end
	endtask

	task automatic send_message(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			send_word(8'($urandom), $urandom_range(0, 9) == 0, i == len - 1);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tags_due.size() != 0) @(posedge clk);
		repeat (PAD_LEN + 40) @(posedge clk);
	endtask

	task automatic write_key(input int idx, input logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= KEY_AW'(idx * KEY_STRIDE);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		key_shadow[idx] = value;
	endtask

	task automatic load_key(input key_t k);
		for (int w = 0; w < KEY_WORDS; w++)
			write_key(w, k[w]);
		keys_loaded++;
	endtask

	task automatic test_empty_and_extremes();
		send_word(8'h00, 1'b1, 1'b1);
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'hFF, 1'b0, 1'b1);
		wait_idle();
		load_key(make_key(KEY_ONES));
		send_word(8'hFF, 1'b0, 1'b0);
		send_word(8'h00, 1'b0, 1'b0);
		send_word(8'hA5, 1'b1, 1'b1);
		wait_idle();
	endtask

	task automatic test_key_boundaries();
		key_t k;
		k = make_key(KEY_FULL);
		k[KEY_WORDS - 1][63:56] = 8'h00;
		load_key(k);
		send_word(8'h5A, 1'b0, 1'b0);
		send_word(8'hC3, 1'b0, 1'b1);
		wait_idle();
		k = make_key(KEY_FULL);
		k[0][7:0] = 8'h00;
		load_key(k);
		send_word(8'h01, 1'b0, 1'b1);
		wait_idle();
		load_key(make_key(KEY_FULL));
		send_word(8'h80, 1'b0, 1'b0);
		send_word(8'h7F, 1'b0, 1'b0);
		send_word(8'h3C, 1'b0, 1'b1);
		wait_idle();
		load_key(make_key(KEY_CUT));
		send_word(8'h42, 1'b0, 1'b1);
		wait_idle();
	endtask

	task automatic test_no_data_words();
		send_word(8'hEE, 1'b1, 1'b0);
		send_word(8'h12, 1'b0, 1'b0);
		send_word(8'h34, 1'b1, 1'b0);
		send_word(8'h56, 1'b0, 1'b1);
		send_word(8'h99, 1'b1, 1'b0);
		send_word(8'h66, 1'b1, 1'b1);
		wait_idle();
	endtask

	task automatic test_key_mid_message();
		send_word(8'h11, 1'b0, 1'b0);
		wait_idle();
		load_key(make_key(KEY_RAW));
		send_word(8'h22, 1'b0, 1'b1);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int unsigned n;
		int unsigned len;
		n = 0;
		while (n < RANDOM_WORDS) begin
			if ($urandom_range(0, 7) == 0) begin
				wait_idle();
				load_key(make_key(key_kind_t'($urandom_range(KEY_ZERO, KEY_CUT))));
				idle_on = $urandom_range(0, 3) != 0;
			end
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
			send_message(len);
			n += len;
		end
		wait_idle();
		idle_on = 1'b1;
	endtask

	task automatic test_back_to_back();
		int unsigned n;
		int unsigned len;
		idle_on = 1'b0;
		n = 0;
		while (n < 40) begin
			len = $urandom_range(1, 6);
			send_message(len);
			n += len;
		end
		wait_idle();
		idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		@(posedge clk);
		hold_req = 600;
		for (int m = 0; m < 12; m++)
			send_message($urandom_range(1, 2));
		wait_idle();
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		test_empty_and_extremes();
		test_key_boundaries();
		test_no_data_words();
		test_key_mid_message();
		test_back_to_back();
		test_backpressure();
		test_random_traffic();
		$display("Sent %0d words in %0d messages under %0d key loads; %0d tags compared.",
			words_sent, msgs_sent, keys_loaded, tags_seen);
		$display("Covered empty and no-data messages, key cut points, mid-message rekey and stalls.");
		if (errors == 0 && tags_due.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
